// ----- rtl/rtbm_pkg.sv -----
`timescale 1ns / 1ps

package rtbm_pkg;

    // Table geometry
    localparam int ENTRIES    = 64;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_WRITE,
        CMD_CLEAR,
        CMD_LOOKUP
    } cmd_kind_t;

    // Classified request; key is the destination on a write, the address on a lookup
    typedef struct packed {
        cmd_kind_t   kind;
        idx_t        slot;
        logic [31:0] key;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [15:0] metric;
        logic [7:0]  intf;
    } cmd_t;

    // One stored route
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [15:0] metric;
        logic [7:0]  intf;
    } entry_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_RESULT
    } back_state_t;

endpackage

// ----- rtl/route_table_best_match.sv -----
`timescale 1ns / 1ps
// Write or clear request: queued, then applied by the back end from idle once the
// output register is free. Lookup request: the back end reads one stored route per
// cycle from the table memory and takes no new request until its result is loaded.
// Writes are taken at one per cycle while the output register is not stalled.
// Reset (rst_n, async low) clears all slot valid bits, the queue and the control
// state; route fields are not cleared and no clearing pass runs.

module route_table_best_match
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [5:0]  entry_index,
    input  logic        entry_valid,
    input  logic [31:0] route_dest,
    input  logic [31:0] route_mask,
    input  logic [31:0] route_gateway,
    input  logic [15:0] route_metric,
    input  logic [7:0]  route_interface,
    input  logic [31:0] lookup_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [5:0]  found_index,
    output logic [31:0] next_hop,
    output logic [7:0]  out_interface,
    output logic [15:0] out_metric
);

    rtbm_pkg::fifo_status_t q_status;
    rtbm_pkg::cmd_t         push_cmd;
    rtbm_pkg::cmd_t         head_cmd;
    logic                   push;
    logic                   pop;

    rtbm_front u_front
    (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .entry_valid     (entry_valid),
        .route_dest      (route_dest),
        .route_mask      (route_mask),
        .route_gateway   (route_gateway),
        .route_metric    (route_metric),
        .route_interface (route_interface),
        .lookup_address  (lookup_address),
        .q_status        (q_status),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    rtbm_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (head_cmd),
        .status   (q_status)
    );

    rtbm_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .found_index   (found_index),
        .next_hop      (next_hop),
        .out_interface (out_interface),
        .out_metric    (out_metric)
    );

endmodule

// ----- rtl/rtbm_front.sv -----
`timescale 1ns / 1ps

module rtbm_front
(
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [5:0]            entry_index,
    input  logic                  entry_valid,
    input  logic [31:0]           route_dest,
    input  logic [31:0]           route_mask,
    input  logic [31:0]           route_gateway,
    input  logic [15:0]           route_metric,
    input  logic [7:0]            route_interface,
    input  logic [31:0]           lookup_address,
    input  rtbm_pkg::fifo_status_t q_status,
    output logic                  push,
    output rtbm_pkg::cmd_t        push_cmd
);

    logic slot_in_range;

    assign slot_in_range = ({26'd0, entry_index} < 32'(rtbm_pkg::ENTRIES));

    // Hold the request while the queue is full
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // Classify the request and normalize the gateway
    always_comb
    begin
        push_cmd         = '0;
        push_cmd.slot    = rtbm_pkg::idx_t'(entry_index);
        push_cmd.mask    = route_mask;
        push_cmd.metric  = route_metric;
        push_cmd.intf    = route_interface;
        push_cmd.gateway = (route_gateway == rtbm_pkg::ALL_ONES) ? 32'd0 : route_gateway;
        if (opcode == rtbm_pkg::OP_LOOKUP)
        begin
            push_cmd.kind = rtbm_pkg::CMD_LOOKUP;
            push_cmd.key  = lookup_address;
        end
        else
        begin
            push_cmd.key = route_dest;
            if (!slot_in_range)
            begin
                push_cmd.kind = rtbm_pkg::CMD_NOP;
            end
            else if (entry_valid)
            begin
                push_cmd.kind = rtbm_pkg::CMD_WRITE;
            end
            else
            begin
                push_cmd.kind = rtbm_pkg::CMD_CLEAR;
            end
        end
    end

endmodule

// ----- rtl/rtbm_queue.sv -----
`timescale 1ns / 1ps

module rtbm_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rtbm_pkg::cmd_t         push_cmd,
    input  logic                   pop,
    output rtbm_pkg::cmd_t         pop_cmd,
    output rtbm_pkg::fifo_status_t status
);

    rtbm_pkg::cmd_t                 slot_reg [rtbm_pkg::FIFO_DEPTH];
    logic [rtbm_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [rtbm_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [rtbm_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [rtbm_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [rtbm_pkg::FIFO_AW:0]     count_reg;
    logic [rtbm_pkg::FIFO_AW:0]     count_next;

    assign status.full  = (count_reg == (rtbm_pkg::FIFO_AW + 1)'(rtbm_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == (rtbm_pkg::FIFO_AW)'(rtbm_pkg::FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == (rtbm_pkg::FIFO_AW)'(rtbm_pkg::FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/rtbm_back.sv -----
`timescale 1ns / 1ps

module rtbm_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtbm_pkg::fifo_status_t q_status,
    input  rtbm_pkg::cmd_t         head_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [5:0]             found_index,
    output logic [31:0]            next_hop,
    output logic [7:0]             out_interface,
    output logic [15:0]            out_metric
);

    // Route storage and per-slot valid bits
    rtbm_pkg::entry_t               table_mem [rtbm_pkg::ENTRIES];
    rtbm_pkg::entry_t               rd_data_reg;
    logic [rtbm_pkg::ENTRIES-1:0]   valid_reg;
    logic [rtbm_pkg::ENTRIES-1:0]   valid_next;
    logic                           mem_we;
    rtbm_pkg::entry_t               mem_wdata;

    rtbm_pkg::back_state_t          state_reg;
    rtbm_pkg::back_state_t          state_next;
    rtbm_pkg::idx_t                 rd_idx_reg;
    rtbm_pkg::idx_t                 rd_idx_next;
    logic [31:0]                    addr_reg;
    logic [31:0]                    addr_next;

    // Compare stage
    logic                           cmp_vld_reg;
    logic                           cmp_vld_next;
    logic                           cmp_slot_valid_reg;
    rtbm_pkg::idx_t                 cmp_idx_reg;
    logic                           cmp_match;
    logic                           cmp_better;
    logic                           take;

    // Running best route
    logic                           hit_reg;
    logic                           hit_next;
    rtbm_pkg::idx_t                 best_idx_reg;
    rtbm_pkg::entry_t               best_reg;

    // Output register
    logic                           out_free;
    logic                           load_out;
    logic                           load_hit;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           found_reg;
    logic [5:0]                     found_index_reg;
    logic [31:0]                    next_hop_reg;
    logic [7:0]                     out_interface_reg;
    logic [15:0]                    out_metric_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // Match and rank the entry held in the table read register
    assign cmp_match  = ((rd_data_reg.dest ^ addr_reg) & rd_data_reg.mask) == 32'd0;
    assign cmp_better = !hit_reg ||
                        (rd_data_reg.mask > best_reg.mask) ||
                        ((rd_data_reg.mask == best_reg.mask) &&
                         (rd_data_reg.metric < best_reg.metric));
    assign take       = cmp_vld_reg && cmp_slot_valid_reg && cmp_match && cmp_better;

    // Sequence requests: write or clear a slot from idle, scan the table for a lookup
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        addr_next      = addr_reg;
        valid_next     = valid_reg;
        hit_next       = hit_reg || take;
        cmp_vld_next   = 1'b0;
        pop            = 1'b0;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        load_hit       = 1'b0;
        mem_wdata.dest    = head_cmd.key;
        mem_wdata.mask    = head_cmd.mask;
        mem_wdata.gateway = head_cmd.gateway;
        mem_wdata.metric  = head_cmd.metric;
        mem_wdata.intf    = head_cmd.intf;
        case (state_reg)
            rtbm_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    case (head_cmd.kind)
                        rtbm_pkg::CMD_LOOKUP:
                        begin
                            pop         = 1'b1;
                            addr_next   = head_cmd.key;
                            rd_idx_next = '0;
                            hit_next    = 1'b0;
                            state_next  = rtbm_pkg::BK_SCAN;
                        end
                        rtbm_pkg::CMD_WRITE:
                        begin
                            if (out_free)
                            begin
                                pop                      = 1'b1;
                                mem_we                   = 1'b1;
                                valid_next[head_cmd.slot] = 1'b1;
                                load_out                 = 1'b1;
                            end
                        end
                        rtbm_pkg::CMD_CLEAR:
                        begin
                            if (out_free)
                            begin
                                pop                      = 1'b1;
                                valid_next[head_cmd.slot] = 1'b0;
                                load_out                 = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                pop      = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                    endcase
                end
            end
            rtbm_pkg::BK_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (rd_idx_reg == rtbm_pkg::idx_t'(rtbm_pkg::ENTRIES - 1))
                begin
                    state_next = rtbm_pkg::BK_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            rtbm_pkg::BK_DRAIN:
            begin
                state_next = rtbm_pkg::BK_RESULT;
            end
            rtbm_pkg::BK_RESULT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_hit   = hit_reg;
                    state_next = rtbm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rtbm_pkg::BK_IDLE;
            end
        endcase
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtbm_pkg::BK_IDLE;
            valid_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Write the table and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[head_cmd.slot] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rd_idx_reg];
    end

    // Hold scan payload and the running best
    always_ff @(posedge clk)
    begin
        rd_idx_reg         <= rd_idx_next;
        addr_reg           <= addr_next;
        cmp_idx_reg        <= rd_idx_reg;
        cmp_slot_valid_reg <= valid_reg[rd_idx_reg];
        if (take)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_reg     <= rd_data_reg;
        end
    end

    // Load the result; drop to zeros on a write, a clear, a dropped request or a miss
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg         <= load_hit;
            found_index_reg   <= load_hit ? 6'(best_idx_reg) : 6'd0;
            next_hop_reg      <= load_hit ? best_reg.gateway : 32'd0;
            out_interface_reg <= load_hit ? best_reg.intf : 8'd0;
            out_metric_reg    <= load_hit ? best_reg.metric : 16'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign found_index   = found_index_reg;
    assign next_hop      = next_hop_reg;
    assign out_interface = out_interface_reg;
    assign out_metric    = out_metric_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == rtbm_pkg::BK_IDLE))
        else $error("queue popped outside idle");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while held");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == rtbm_pkg::BK_SCAN || state_reg == rtbm_pkg::BK_DRAIN))
        else $error("compare stage active outside scan");

    a_drain_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtbm_pkg::BK_DRAIN) |=> (state_reg == rtbm_pkg::BK_RESULT))
        else $error("drain did not reach result");

endmodule
